/* hw/rtl/csl_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// csl_pkg: shared types and constants for the cube surface to LED index block
// Side length limits, reciprocal format and inter-stage request types.
// ----------------------------------------------------------------------------
package csl_pkg;

	localparam int SIDE_MAX    = 64;
	localparam int SIDE_W      = 7;
	localparam int SIDE_IDX_W  = 6;
	localparam logic [SIDE_W-1:0] SIDE_RESET = 7'd8;

	// reciprocal table entry: ceil(2^RECIP_SHIFT / n)
	localparam int RECIP_SHIFT = 24;
	localparam int RECIP_W     = 25;

	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
	} csl_req_t;

	typedef struct packed {
		logic [SIDE_W-1:0] n;
		logic [7:0]        xm;
		logic [7:0]        wy;
		logic [7:0]        red;
		logic [7:0]        green;
		logic [7:0]        blue;
	} csl_wrap_t;

	typedef struct packed {
		logic [14:0] idx;
		logic [7:0]  xm;
		logic [7:0]  wy;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
	} csl_res_t;

	function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
		logic [SIDE_W-1:0] r;
		if (v == '0) begin
			r = SIDE_W'(1);
		end else if (v > SIDE_W'(SIDE_MAX)) begin
			r = SIDE_W'(SIDE_MAX);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/csl_wrap.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// csl_wrap: coordinate wrap pipeline (stages 1 to 4)
// x mod 4n and y mod n via reciprocal multiply, then y folded into -2n..n-1.
// ----------------------------------------------------------------------------
module csl_wrap (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [csl_pkg::SIDE_W-1:0] side_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  csl_pkg::csl_req_t          in_req,
	output logic                       out_valid,
	input  logic                       out_ready,
	output csl_pkg::csl_wrap_t         out_pix
);
	import csl_pkg::*;

	logic [RECIP_W-1:0] recip_tbl [SIDE_MAX];

	for (genvar gi = 0; gi < SIDE_MAX; gi++) begin : g_recip
		localparam logic [RECIP_W-1:0] RV =
			RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(gi)) / 64'(gi + 1));
		assign recip_tbl[gi] = RV;
	end

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	// stage 1
	logic [SIDE_W-1:0]  n_s1;
	logic [15:0]        u_s1, w_s1, y_s1;
	logic [RECIP_W-1:0] r_s1;
	logic [23:0]        rgb_s1;
	logic [SIDE_W-1:0]  side_m1;

	// stage 2
	logic [SIDE_W-1:0] n_s2;
	logic [15:0]       u_s2, w_s2, y_s2;
	logic [13:0]       qx_s2;
	logic [15:0]       qy_s2, cxp_s2, cyp_s2;
	logic [23:0]       rgb_s2;
	logic [40:0]       prodx, prody;
	logic [22:0]       cxprod, cyprod;
	logic [8:0]        m4_s1;

	// stage 3
	logic [SIDE_W-1:0] n_s3;
	logic [15:0]       y_s3;
	logic [7:0]        rx_s3, cx_s3;
	logic [5:0]        ry_s3, cy_s3;
	logic [23:0]       rgb_s3;
	logic [8:0]        m4_s2;
	logic [22:0]       backx, backy;
	logic [15:0]       rx_full, ry_full, cx_full, cy_full;

	// stage 4
	csl_wrap_t   pix_s4;
	logic [8:0]  m4_s3, dx, xm_full;
	logic [6:0]  dy, ym_full;
	logic [15:0] neg2n;
	logic        y_ge, y_lt;
	logic [7:0]  wy;

	assign rdy4     = !v_s4 || out_ready;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	// offset by 2^15 so the dividends are unsigned
	assign side_m1 = side_n - SIDE_W'(1);

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			n_s1   <= side_n;
			u_s1   <= {~in_req.x[15], in_req.x[14:0]};
			w_s1   <= {~in_req.y[15], in_req.y[14:0]};
			y_s1   <= in_req.y;
			r_s1   <= recip_tbl[side_m1[SIDE_IDX_W-1:0]];
			rgb_s1 <= {in_req.blue, in_req.green, in_req.red};
		end
	end

	assign m4_s1  = {n_s1, 2'b00};
	assign prodx  = 41'(u_s1) * 41'(r_s1);
	assign prody  = 41'(w_s1) * 41'(r_s1);
	// 2^15 mod m needs floor(2^15 / m), a plain slice of the reciprocal
	assign cxprod = 23'(r_s1[RECIP_W-1:11]) * 23'(m4_s1);
	assign cyprod = 23'(r_s1[RECIP_W-1:9]) * 23'(n_s1);

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			n_s2   <= n_s1;
			u_s2   <= u_s1;
			w_s2   <= w_s1;
			y_s2   <= y_s1;
			qx_s2  <= prodx[39:26];
			qy_s2  <= prody[39:24];
			cxp_s2 <= cxprod[15:0];
			cyp_s2 <= cyprod[15:0];
			rgb_s2 <= rgb_s1;
		end
	end

	assign m4_s2   = {n_s2, 2'b00};
	assign backx   = 23'(qx_s2) * 23'(m4_s2);
	assign backy   = 23'(qy_s2) * 23'(n_s2);
	assign rx_full = u_s2 - backx[15:0];
	assign ry_full = w_s2 - backy[15:0];
	assign cx_full = 16'h8000 - cxp_s2;
	assign cy_full = 16'h8000 - cyp_s2;

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			n_s3   <= n_s2;
			y_s3   <= y_s2;
			rx_s3  <= rx_full[7:0];
			ry_s3  <= ry_full[5:0];
			cx_s3  <= cx_full[7:0];
			cy_s3  <= cy_full[5:0];
			rgb_s3 <= rgb_s2;
		end
	end

	assign m4_s3   = {n_s3, 2'b00};
	assign dx      = {1'b0, rx_s3} - {1'b0, cx_s3};
	assign xm_full = dx + (dx[8] ? m4_s3 : 9'd0);
	assign dy      = {1'b0, ry_s3} - {1'b0, cy_s3};
	assign ym_full = dy + (dy[6] ? n_s3 : 7'd0);
	assign neg2n   = 16'd0 - {8'd0, n_s3, 1'b0};
	assign y_ge    = $signed(y_s3) >= $signed({9'd0, n_s3});
	assign y_lt    = $signed(y_s3) < $signed(neg2n);

	always_comb begin
		if (y_ge) begin
			wy = {2'b00, ym_full[5:0]};
		end else if (y_lt) begin
			wy = {2'b00, ym_full[5:0]} - {n_s3, 1'b0};
		end else begin
			wy = y_s3[7:0];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4 && v_s3) begin
			pix_s4.n     <= n_s3;
			pix_s4.xm    <= xm_full[7:0];
			pix_s4.wy    <= wy;
			pix_s4.red   <= rgb_s3[7:0];
			pix_s4.green <= rgb_s3[15:8];
			pix_s4.blue  <= rgb_s3[23:16];
		end
	end

	assign out_valid = v_s4;
	assign out_pix   = pix_s4;

`ifndef NO_ASSERTIONS
	a_xm_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> ({1'b0, pix_s4.xm} < {pix_s4.n, 2'b00}))
		else $error("wrapped x not below 4n");

	a_wy_low: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> ($signed({pix_s4.wy[7], pix_s4.wy}) >=
			$signed(9'd0 - {1'b0, pix_s4.n, 1'b0})))
		else $error("wrapped y below -2n");

	a_wy_high: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> ($signed({pix_s4.wy[7], pix_s4.wy}) < $signed({2'b00, pix_s4.n})))
		else $error("wrapped y not below n");
`endif

endmodule
`default_nettype wire

/* hw/rtl/csl_map.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// csl_map: panel mapping pipeline (stages 5 to 7)
// Picks panel and in-panel position, then index = n*(n*panel + py) + px.
// ----------------------------------------------------------------------------
module csl_map (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  csl_pkg::csl_wrap_t in_pix,
	output logic               out_valid,
	input  logic               out_ready,
	output csl_pkg::csl_res_t  out_res
);
	import csl_pkg::*;

	logic v_s5, v_s6, v_s7;
	logic rdy5, rdy6, rdy7;

	// stage 5
	csl_wrap_t  pix_s5;
	logic [2:0] panel_s5;
	logic [5:0] px_s5, py_s5;
	logic [8:0] n1, n2, n3, x9, base, xr9;
	logic [1:0] quad;
	logic [5:0] xr;
	logic [6:0] nm1_xr;
	logic [7:0] negy1, npy, bot_py;
	logic       is_side, is_top;
	logic [2:0] panel;
	logic [5:0] px, py;

	// stage 6
	csl_wrap_t  pix_s6;
	logic [8:0] t_s6;
	logic [5:0] px_s6;
	logic [9:0] np_prod;

	// stage 7
	csl_res_t    res_s7;
	logic [15:0] idx_prod;

	assign rdy7     = !v_s7 || out_ready;
	assign rdy6     = !v_s6 || rdy7;
	assign rdy5     = !v_s5 || rdy6;
	assign in_ready = rdy5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (rdy5) v_s5 <= in_valid;
			if (rdy6) v_s6 <= v_s5;
			if (rdy7) v_s7 <= v_s6;
		end
	end

	assign n1 = {2'b00, in_pix.n};
	assign n2 = {1'b0, in_pix.n, 1'b0};
	assign n3 = n1 + n2;
	assign x9 = {1'b0, in_pix.xm};

	always_comb begin
		if (x9 >= n3) begin
			quad = 2'd3;
			base = n3;
		end else if (x9 >= n2) begin
			quad = 2'd2;
			base = n2;
		end else if (x9 >= n1) begin
			quad = 2'd1;
			base = n1;
		end else begin
			quad = 2'd0;
			base = 9'd0;
		end
	end

	assign xr9     = x9 - base;
	assign xr      = xr9[5:0];
	assign nm1_xr  = in_pix.n - 7'd1 - {1'b0, xr};
	assign negy1   = ~in_pix.wy;
	assign npy     = {1'b0, in_pix.n} + in_pix.wy;
	assign bot_py  = ~in_pix.wy - {1'b0, in_pix.n};
	assign is_side = !in_pix.wy[7];
	assign is_top  = $signed({in_pix.wy[7], in_pix.wy}) >= $signed(9'd0 - n1);

	always_comb begin
		panel = 3'd0;
		px    = xr;
		py    = in_pix.wy[5:0];
		if (is_side) begin
			panel = 3'd1 + {1'b0, quad};
		end else if (is_top) begin
			case (quad)
				2'd0: begin
					px = nm1_xr[5:0];
					py = negy1[5:0];
				end
				2'd1: begin
					px = negy1[5:0];
					py = xr;
				end
				2'd2: begin
					px = xr;
					py = npy[5:0];
				end
				default: begin
					px = npy[5:0];
					py = nm1_xr[5:0];
				end
			endcase
		end else begin
			// mirrored bottom, panel rotated by two
			px = nm1_xr[5:0];
			py = bot_py[5:0];
			case (quad)
				2'd0:    panel = 3'd3;
				2'd1:    panel = 3'd4;
				2'd2:    panel = 3'd1;
				default: panel = 3'd2;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rdy5 && in_valid) begin
			pix_s5   <= in_pix;
			panel_s5 <= panel;
			px_s5    <= px;
			py_s5    <= py;
		end
	end

	assign np_prod = 10'(pix_s5.n) * 10'(panel_s5);

	always_ff @(posedge clk) begin
		if (rdy6 && v_s5) begin
			pix_s6 <= pix_s5;
			t_s6   <= np_prod[8:0] + {3'b000, py_s5};
			px_s6  <= px_s5;
		end
	end

	assign idx_prod = 16'(pix_s6.n) * 16'(t_s6);

	always_ff @(posedge clk) begin
		if (rdy7 && v_s6) begin
			res_s7.idx   <= 15'(idx_prod + {10'd0, px_s6});
			res_s7.xm    <= pix_s6.xm;
			res_s7.wy    <= pix_s6.wy;
			res_s7.red   <= pix_s6.red;
			res_s7.green <= pix_s6.green;
			res_s7.blue  <= pix_s6.blue;
		end
	end

	assign out_valid = v_s7;
	assign out_res   = res_s7;

`ifndef NO_ASSERTIONS
	a_px_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |-> ({1'b0, px_s5} < pix_s5.n))
		else $error("panel x not below n");

	a_py_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |-> ({1'b0, py_s5} < pix_s5.n))
		else $error("panel y not below n");

	a_panel_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |-> (panel_s5 <= 3'd4))
		else $error("panel number above 4");
`endif

endmodule
`default_nettype wire

/* hw/rtl/cube_surface_to_led_index.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cube_surface_to_led_index: surface coordinate to LED strip pixel write
// Wraps a signed coordinate over a five panel cube and gives the strip index.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload (low bit up)
//  s_        in   tvalid / tready    coord_x 16, coord_y 16, red, green, blue
//  m_        out  tvalid / tready    led_index 15, wrapped_x 8, wrapped_y 8,
//                                    out_red, out_green, out_blue, pad 1
//  cfg_      in   we                 panel edge length 7
//
// One request per cycle while the output is not stalled; seven register stages,
// stages 1 to 4 in csl_wrap and stages 5 to 7 in csl_map.
// The stages hold the reciprocal divide (two multiplies) and the index
// multiply-add chain. Reset clears all stage valids, edge length goes to 8.
// A stalled output holds its request; stages behind it keep filling bubbles.
// ----------------------------------------------------------------------------
module cube_surface_to_led_index (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata,   // panel edge length
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,     // coord_x, coord_y, red, green, blue
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata      // led_index, wrapped_x, wrapped_y, r, g, b
);
	import csl_pkg::*;

	logic [SIDE_W-1:0] side_n_q;
	csl_req_t          req;
	csl_wrap_t         pix;
	csl_res_t          res;
	logic              pix_valid, pix_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_n_q <= SIDE_RESET;
		end else if (cfg_we) begin
			side_n_q <= clamp_side(cfg_wdata);
		end
	end

	assign req.x     = s_tdata[15:0];
	assign req.y     = s_tdata[31:16];
	assign req.red   = s_tdata[39:32];
	assign req.green = s_tdata[47:40];
	assign req.blue  = s_tdata[55:48];

	csl_wrap u_wrap (
		.clk       (clk),
		.arst_n    (arst_n),
		.side_n    (side_n_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_req    (req),
		.out_valid (pix_valid),
		.out_ready (pix_ready),
		.out_pix   (pix)
	);

	csl_map u_map (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pix_valid),
		.in_ready  (pix_ready),
		.in_pix    (pix),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	assign m_tdata = {1'b0, res.blue, res.green, res.red, res.wy, res.xm, res.idx};

endmodule
`default_nettype wire

/* tb/cube_pixel_checker.sv */
// ----------------------------------------------------------------------------
// cube_pixel_checker: prediction and comparison of LED strip pixel writes
// Tracks panel edge length writes, predicts the strip write for every accepted
// input request and compares each output request with the oldest prediction.
// ----------------------------------------------------------------------------
module cube_pixel_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [55:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [55:0] m_tdata,
	output int          outstanding,
	output int          errors
);
	import csl_pkg::*;

	typedef struct packed {
		logic [14:0] led_index;
		logic [7:0]  wrapped_x;
		logic [7:0]  wrapped_y;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic        pad;
	} strip_write_t;

	strip_write_t      pixel_q[$];
	strip_write_t      want;
	strip_write_t      got;
	logic [SIDE_W-1:0] side_reg;

	// x wraps over four sides, y into -2N..N-1, then piecewise panel mapping
	function automatic strip_write_t map_pixel(input logic [55:0] req,
		input logic [SIDE_W-1:0] side);
		strip_write_t w;
		shortint      sx;
		shortint      sy;
		int           n;
		int           x;
		int           y;
		int           r;
		int           panel;
		int           px;
		int           py;
		int           idx;
		n = (side == 0) ? 1 : ((side > SIDE_MAX) ? SIDE_MAX : int'(side));
		sx = req[15:0];
		sy = req[31:16];
		x = sx;
		y = sy;
		x = x % (4 * n);
		if (x < 0) begin
			x += 4 * n;
		end
		if (y >= n) begin
			y = y % n;
		end else if (y < -2 * n) begin
			r = (y + 2 * n) % n;
			if (r < 0) begin
				r += n;
			end
			y = -2 * n + r;
		end
		panel = 0;
		px = 0;
		py = y;
		if (y >= 0) begin
			panel = 1 + x / n;
			px = x % n;
		end else if (y >= -n) begin
			// top panel, rotated by quadrant of x
			if (x < n) begin
				px = n - 1 - x;
				py = -y - 1;
			end else if (x < 2 * n) begin
				px = -y - 1;
				py = x - n;
			end else if (x < 3 * n) begin
				px = x - 2 * n;
				py = n + y;
			end else begin
				px = n + y;
				py = n - 1 - (x - 3 * n);
			end
		end else begin
			// mirrored bottom view
			py = -y - n - 1;
			px = n - 1 - x % n;
			panel = 3 + x / n;
			if (panel > 4) begin
				panel -= 4;
			end
		end
		idx = n * n * panel + n * py + px;
		w.led_index = idx[14:0];
		w.wrapped_x = x[7:0];
		w.wrapped_y = y[7:0];
		w.red = req[39:32];
		w.green = req[47:40];
		w.blue = req[55:48];
		w.pad = 1'b0;
		return w;
	endfunction

	function automatic strip_write_t unpack_write(input logic [55:0] d);
		strip_write_t w;
		w.led_index = d[14:0];
		w.wrapped_x = d[22:15];
		w.wrapped_y = d[30:23];
		w.red = d[38:31];
		w.green = d[46:39];
		w.blue = d[54:47];
		w.pad = d[55];
		return w;
	endfunction

	task automatic check_field(input string name, input int exp_val, input int act_val);
		if (exp_val !== act_val) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, exp_val, act_val);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_reg <= SIDE_RESET;
			pixel_q.delete();
			outstanding <= 0;
			errors = 0;
		end else begin
			if (cfg_we) begin
				side_reg <= cfg_wdata;
			end
			if (s_tvalid && s_tready) begin
				pixel_q.push_back(map_pixel(s_tdata, side_reg));
			end
			if (m_tvalid && m_tready) begin
				got = unpack_write(m_tdata);
				if (pixel_q.size() == 0) begin
					$display("%0t: no request expected, actual tdata %h", $time, m_tdata);
					errors++;
				end else begin
					want = pixel_q.pop_front();
					check_field("led_index", want.led_index, got.led_index);
					check_field("wrapped_x", want.wrapped_x, got.wrapped_x);
					check_field("wrapped_y", want.wrapped_y, got.wrapped_y);
					check_field("out_red", want.red, got.red);
					check_field("out_green", want.green, got.green);
					check_field("out_blue", want.blue, got.blue);
					check_field("pad", want.pad, got.pad);
				end
			end
			outstanding <= pixel_q.size();
		end
	end

endmodule

/* tb/tb_cube_surface_to_led_index.sv */
// ----------------------------------------------------------------------------
// tb_cube_surface_to_led_index: stimulus and verdict for the strip mapper
// Directed corner requests, then random coordinates over several side
// lengths with random gaps on both streams; a checker compares each write.
// ----------------------------------------------------------------------------
module tb_cube_surface_to_led_index;
	import csl_pkg::*;

	localparam int PHASE_ITEMS = 172;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [6:0]  cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;
	int          outstanding;
	int          errors;

	int          side_n = SIDE_RESET;
	bit          src_idle = 1'b1;
	bit          sink_idle = 1'b1;
	int          sink_run = 0;

	always #5 clk = ~clk;

	cube_surface_to_led_index dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	cube_pixel_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.outstanding (outstanding),
		.errors      (errors)
	);

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		if ($urandom_range(0, 15) == 0) begin
			return $urandom_range(10, 40);
		end
		return $urandom_range(1, 3);
	endfunction

	function automatic logic [15:0] pick_x(input int n);
		int v;
		case ($urandom_range(0, 9))
			0, 1: v = $urandom;
			2: begin
				case ($urandom_range(0, 3))
					0: v = -32768;
					1: v = 32767;
					2: v = -1;
					default: v = 4 * n - 1;
				endcase
			end
			default: v = int'($urandom_range(0, 24 * n)) - 12 * n;
		endcase
		return v[15:0];
	endfunction

	function automatic logic [15:0] pick_y(input int n);
		int v;
		case ($urandom_range(0, 9))
			0, 1: v = $urandom;
			2: begin
				case ($urandom_range(0, 7))
					0: v = n - 1;
					1: v = n;
					2: v = -1;
					3: v = -n;
					4: v = -n - 1;
					5: v = -2 * n;
					6: v = -2 * n - 1;
					default: v = 0;
				endcase
			end
			default: v = int'($urandom_range(0, 8 * n)) - 5 * n;
		endcase
		return v[15:0];
	endfunction

	// sink side: random stalls, or always ready
	always @(posedge clk) begin
		if (sink_run > 0) begin
			sink_run <= sink_run - 1;
		end else if (!sink_idle || $urandom_range(0, 3) != 0) begin
			m_tready <= 1'b1;
			sink_run <= $urandom_range(0, 6);
		end else begin
			m_tready <= 1'b0;
			sink_run <= pick_gap();
		end
	end

	task automatic send_req(input logic [55:0] d);
		int gap;
		gap = (src_idle && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= d;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_pix(input int x, input int y, input logic [7:0] r,
		input logic [7:0] g, input logic [7:0] b);
		send_req({b, g, r, 16'(y), 16'(x)});
	endtask

	task automatic send_random(input int count);
		repeat (count) begin
			send_req({8'($urandom), 8'($urandom), 8'($urandom), pick_y(side_n),
				pick_x(side_n)});
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic write_side(input logic [6:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		side_n = (v == 0) ? 1 : ((v > SIDE_MAX) ? SIDE_MAX : int'(v));
	endtask

	task automatic pick_idling();
		src_idle = $urandom_range(0, 3) != 0;
		sink_idle = $urandom_range(0, 3) != 0;
	endtask

	initial begin
		int side_plan[10] = '{0, 1, 64, 127, 65, 2, 3, 0, 0, 0};
		side_plan[7] = $urandom_range(4, 63);
		side_plan[8] = $urandom_range(4, 63);
		side_plan[9] = $urandom_range(0, 127);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corners at the reset side length of 8
		send_pix(-32768, -32768, 8'h00, 8'h00, 8'h00);
		send_pix(32767, 32767, 8'hff, 8'hff, 8'hff);
		send_pix(0, 0, 8'h01, 8'h80, 8'h7f);
		send_pix(-1, -1, 8'hfe, 8'h02, 8'haa);
		send_pix(32767, -32768, 8'h55, 8'hcc, 8'h33);
		send_pix(-32768, 32767, 8'h0f, 8'hf0, 8'h99);
		send_pix(31, 7, 8'h12, 8'h34, 8'h56);
		send_pix(32, 8, 8'h78, 8'h9a, 8'hbc);
		send_pix(0, -1, 8'h10, 8'h20, 8'h30);
		send_pix(8, -1, 8'h40, 8'h50, 8'h60);
		send_pix(16, -1, 8'h70, 8'h80, 8'h90);
		send_pix(24, -1, 8'ha0, 8'hb0, 8'hc0);
		send_pix(31, -1, 8'hd0, 8'he0, 8'hf0);
		send_pix(3, -8, 8'h11, 8'h22, 8'h33);
		send_pix(5, -9, 8'h44, 8'h55, 8'h66);
		send_pix(12, -16, 8'h77, 8'h88, 8'h99);
		send_pix(20, -17, 8'haa, 8'hbb, 8'hcc);
		send_pix(16, -12, 8'hdd, 8'hee, 8'hff);
		send_pix(24, -12, 8'h01, 8'h02, 8'h03);
		send_pix(0, -12, 8'h04, 8'h05, 8'h06);

		pick_idling();
		send_random(PHASE_ITEMS);
		drain();

		foreach (side_plan[i]) begin
			write_side(7'(side_plan[i]));
			pick_idling();
			send_random(PHASE_ITEMS);
			drain();
		end

		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("cube_surface_to_led_index: match");
		end else begin
			$display("cube_surface_to_led_index: mismatch");
		end
		$finish;
	end

	initial begin
		#8_000_000;
		$display("cube_surface_to_led_index: mismatch");
		$finish;
	end

endmodule
